// ----- design/mtlbw_pkg.sv -----
// ----------------------------------------------------------------------------
// mtlbw_pkg: shared definitions for the multi-task leaky bucket watchdog
// Widths, register indexes, reset values and the structs passed between
// the top level and the bucket update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtlbw_pkg;

	localparam int TASK_COUNT = 3;
	localparam int TASK_W     = 2;
	localparam int PERIOD_W   = 16;
	localparam int STEP_W     = 7;
	localparam int LEVEL_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_SLOW = 3'd0,
		REG_PERIOD_MID  = 3'd1,
		REG_PERIOD_FAST = 3'd2,
		REG_BUCKET_MAX  = 3'd3,
		REG_PET_STEP    = 3'd4,
		REG_TICK_STEP   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		MODE_PET  = 1'b0,
		MODE_TICK = 1'b1
	} evt_mode_t;

	localparam logic [TASK_W-1:0] TASK_SLOW = 2'd0;
	localparam logic [TASK_W-1:0] TASK_MID  = 2'd1;
	localparam logic [TASK_W-1:0] TASK_FAST = 2'd2;

	localparam logic [PERIOD_W-1:0]       PERIOD_SLOW_RST = 16'd1000;
	localparam logic [PERIOD_W-1:0]       PERIOD_MID_RST  = 16'd100;
	localparam logic [PERIOD_W-1:0]       PERIOD_FAST_RST = 16'd1;
	localparam logic [STEP_W-1:0]         BUCKET_MAX_RST  = 7'd5;
	localparam logic [STEP_W-1:0]         PET_STEP_RST    = 7'd2;
	localparam logic [STEP_W-1:0]         TICK_STEP_RST   = 7'd1;
	localparam logic signed [LEVEL_W-1:0] BUCKET_RST      = 16'sd5;
	localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR     = 16'sh8000;

	// per-task state: prescale counter and signed bucket
	typedef struct packed {
		logic [PERIOD_W-1:0]       counter;
		logic signed [LEVEL_W-1:0] bucket;
	} task_state_t;

	// controls for one update of the addressed task
	typedef struct packed {
		evt_mode_t           mode;
		logic [PERIOD_W-1:0] period;
		logic [STEP_W-1:0]   bucket_max;
		logic [STEP_W-1:0]   pet_step;
		logic [STEP_W-1:0]   tick_step;
	} upd_ctrl_t;

endpackage

`default_nettype wire

// ----- design/mtlbw_if.sv -----
// ----------------------------------------------------------------------------
// mtlbw_if: channel interfaces of the watchdog
// Event input, result output and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtlbw_evt_if import mtlbw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [TASK_W-1:0] task_req;

	modport source (output valid, output mode, output task_req, input ready);
	modport sink   (input valid, input mode, input task_req, output ready);
endinterface

interface mtlbw_res_if import mtlbw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      expired;
	logic [TASK_W-1:0]         recent_task;
	logic [TASK_COUNT-1:0]     expired_mask;
	logic                      expired_now;
	logic signed [LEVEL_W-1:0] bucket_level;

	modport source (output valid, output expired, output recent_task,
		output expired_mask, output expired_now, output bucket_level, input ready);
	modport sink   (input valid, input expired, input recent_task,
		input expired_mask, input expired_now, input bucket_level, output ready);
endinterface

interface mtlbw_cfg_if import mtlbw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/mtlbw_bucket_upd.sv -----
// ----------------------------------------------------------------------------
// mtlbw_bucket_upd: next-state logic for one task
// Pet adds with a cap; tick advances the prescaler and, past the period,
// drains the bucket, saturating at the signed floor; flags expiry on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mtlbw_bucket_upd import mtlbw_pkg::*; (
	input  upd_ctrl_t   ctrl,
	input  task_state_t cur,
	output task_state_t nxt,
	output logic        expire_now
);

	logic signed [LEVEL_W:0] bucket_x;
	logic signed [LEVEL_W:0] pet_sum;
	logic signed [LEVEL_W:0] cap_x;
	logic signed [LEVEL_W:0] drain;
	logic [PERIOD_W:0]       cnt_inc;
	logic                    elapsed;

	assign bucket_x = {cur.bucket[LEVEL_W-1], cur.bucket};
	assign cap_x    = $signed({{(LEVEL_W+1-STEP_W){1'b0}}, ctrl.bucket_max});
	assign pet_sum  = bucket_x + $signed({{(LEVEL_W+1-STEP_W){1'b0}}, ctrl.pet_step});
	assign drain    = bucket_x - $signed({{(LEVEL_W+1-STEP_W){1'b0}}, ctrl.tick_step});
	assign cnt_inc  = {1'b0, cur.counter} + {{PERIOD_W{1'b0}}, 1'b1};
	assign elapsed  = cnt_inc > {1'b0, ctrl.period};

	always_comb begin
		nxt        = cur;
		expire_now = 1'b0;
		unique case (ctrl.mode)
			MODE_PET: begin
				if (pet_sum > cap_x) begin
					nxt.bucket = cap_x[LEVEL_W-1:0];
				end else begin
					nxt.bucket = pet_sum[LEVEL_W-1:0];
				end
			end
			MODE_TICK: begin
				if (elapsed) begin
					nxt.counter = '0;
					// saturate at the signed floor instead of wrapping
					if (drain < $signed({LEVEL_FLOOR[LEVEL_W-1], LEVEL_FLOOR})) begin
						nxt.bucket = LEVEL_FLOOR;
					end else begin
						nxt.bucket = drain[LEVEL_W-1:0];
					end
				end else begin
					nxt.counter = cnt_inc[PERIOD_W-1:0];
				end
				expire_now = nxt.bucket[LEVEL_W-1] || (nxt.bucket == '0);
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/multi_task_leaky_bucket_watchdog.sv -----
// ----------------------------------------------------------------------------
// multi_task_leaky_bucket_watchdog: three-task leaky bucket watchdog
// Pet and tick events per task, with sticky expiry reporting.
// ----------------------------------------------------------------------------
// Each event transaction names a task (0 slow, 1 medium, 2 fast) and either
// pets it (bucket += pet_step, capped at bucket_max) or ticks it (prescale
// counter advances; once it passes the task's period the bucket drops by
// tick_step, floored at -32768, and the counter clears). Every event returns
// exactly one result transaction: the sticky expired flag, the last expired
// task, the sticky per-task mask, whether this tick left the bucket at or
// below zero, and the addressed bucket after the event. Task index 3 changes
// nothing and reports a zero level. The block takes one event per clock
// while the result side is not stalled; each event passes through an input
// register and a result register, and the per-task state is read and written
// as the event leaves the input register, so back-to-back events on the
// same task need no forwarding. Configuration writes are always accepted and
// should only be issued while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_task_leaky_bucket_watchdog import mtlbw_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	mtlbw_evt_if.sink     evt,
	mtlbw_res_if.source   res,
	mtlbw_cfg_if.sink     cfg
);

	// configuration registers
	logic [PERIOD_W-1:0] period_slow_q;
	logic [PERIOD_W-1:0] period_mid_q;
	logic [PERIOD_W-1:0] period_fast_q;
	logic [STEP_W-1:0]   bucket_max_q;
	logic [STEP_W-1:0]   pet_step_q;
	logic [STEP_W-1:0]   tick_step_q;

	// per-task state and sticky status
	task_state_t           state_q [TASK_COUNT];
	logic                  expired_q;
	logic [TASK_W-1:0]     last_expired_q;
	logic [TASK_COUNT-1:0] expired_bits_q;

	// input register
	logic              valid_s1;
	evt_mode_t         mode_s1;
	logic [TASK_W-1:0] task_s1;

	// result register
	logic                      res_valid_q;
	logic                      res_expired_q;
	logic [TASK_W-1:0]         res_task_q;
	logic [TASK_COUNT-1:0]     res_mask_q;
	logic                      res_now_q;
	logic signed [LEVEL_W-1:0] res_level_q;

	logic                  evt_accept;
	logic                  adv_s1;
	logic                  task_ok;
	upd_ctrl_t             ctrl;
	task_state_t           cur_state;
	task_state_t           nxt_state;
	logic                  upd_now;
	logic                  now_s1;
	logic                  expired_nxt;
	logic [TASK_W-1:0]     last_nxt;
	logic [TASK_COUNT-1:0] bits_nxt;
	logic [TASK_COUNT-1:0] task_onehot;

	// handshake: the result register frees the input register
	assign adv_s1     = valid_s1 && (!res_valid_q || res.ready);
	assign evt.ready  = !valid_s1 || adv_s1;
	assign evt_accept = evt.valid && evt.ready;
	assign cfg.ready  = 1'b1;

	// task index 3 is a no-op
	assign task_ok = (task_s1 == TASK_SLOW) || (task_s1 == TASK_MID) ||
		(task_s1 == TASK_FAST);

	always_comb begin
		ctrl.mode       = mode_s1;
		ctrl.bucket_max = bucket_max_q;
		ctrl.pet_step   = pet_step_q;
		ctrl.tick_step  = tick_step_q;
		unique case (task_s1)
			TASK_SLOW: ctrl.period = period_slow_q;
			TASK_MID:  ctrl.period = period_mid_q;
			default:   ctrl.period = period_fast_q;
		endcase
		cur_state = task_ok ? state_q[task_s1] : '0;
	end

	mtlbw_bucket_upd u_upd (
		.ctrl       (ctrl),
		.cur        (cur_state),
		.nxt        (nxt_state),
		.expire_now (upd_now)
	);

	// sticky status after this event
	assign task_onehot = TASK_COUNT'(1) << task_s1;
	assign now_s1      = task_ok && upd_now;
	assign expired_nxt = expired_q || now_s1;
	assign last_nxt    = now_s1 ? task_s1 : last_expired_q;
	assign bits_nxt    = now_s1 ? (expired_bits_q | task_onehot) : expired_bits_q;

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_slow_q <= PERIOD_SLOW_RST;
			period_mid_q  <= PERIOD_MID_RST;
			period_fast_q <= PERIOD_FAST_RST;
			bucket_max_q  <= BUCKET_MAX_RST;
			pet_step_q    <= PET_STEP_RST;
			tick_step_q   <= TICK_STEP_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PERIOD_SLOW: period_slow_q <= cfg.data;
				REG_PERIOD_MID:  period_mid_q  <= cfg.data;
				REG_PERIOD_FAST: period_fast_q <= cfg.data;
				REG_BUCKET_MAX:  bucket_max_q  <= cfg.data[STEP_W-1:0];
				REG_PET_STEP:    pet_step_q    <= cfg.data[STEP_W-1:0];
				REG_TICK_STEP:   tick_step_q   <= cfg.data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// task state and sticky status update as the event leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				state_q[i].counter <= '0;
				state_q[i].bucket  <= BUCKET_RST;
			end
			expired_q      <= 1'b0;
			last_expired_q <= '0;
			expired_bits_q <= '0;
		end else if (adv_s1 && task_ok) begin
			state_q[task_s1] <= nxt_state;
			expired_q        <= expired_nxt;
			last_expired_q   <= last_nxt;
			expired_bits_q   <= bits_nxt;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_accept) begin
			mode_s1 <= evt_mode_t'(evt.mode);
			task_s1 <= evt.task_req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_expired_q <= expired_nxt;
			res_task_q    <= last_nxt;
			res_mask_q    <= bits_nxt;
			res_now_q     <= now_s1;
			res_level_q   <= task_ok ? nxt_state.bucket : '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.expired      = res_expired_q;
	assign res.recent_task  = res_task_q;
	assign res.expired_mask = res_mask_q;
	assign res.expired_now  = res_now_q;
	assign res.bucket_level = res_level_q;

	// the expired mask never loses a bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(expired_bits_q & $past(expired_bits_q)) == $past(expired_bits_q))
		else $error("sticky expired mask lost a bit");

	// an expiry reported now shows up in the flag and in the mask for its task
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.expired_now) |->
		(res.expired && (((res.expired_mask >> res.recent_task) & 3'd1) == 3'd1)))
		else $error("expiry not reflected in sticky status");

	// no bucket ever rises above the largest cap
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.bucket_level <= 16'sd127))
		else $error("bucket level above cap range");

	// sticky status only moves when an event leaves the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv_s1) |-> ($stable(expired_bits_q) && $stable(expired_q)))
		else $error("status changed without an event");

endmodule

`default_nettype wire
